[rtl/core/etp_pkg.sv]
// Package for the Ethernet/IPv4 transport header parser.
// Holds the shared types, codes and constants; it depends on nothing else.
package etp_pkg;

  localparam int unsigned PAYLOAD_BYTES   = 16;
  localparam int unsigned MAX_FRAME_BYTES = 65535;
  localparam int unsigned POS_W           = 16;
  localparam int unsigned PCNT_W          = $clog2(PAYLOAD_BYTES + 1);
  localparam int unsigned PIDX_W          = 4;

  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);
  localparam logic [PCNT_W-1:0] PCNT_LIMIT = PCNT_W'(PAYLOAD_BYTES);

  localparam logic [7:0] ETYPE_HI    = 8'h08;
  localparam logic [7:0] ETYPE_LO    = 8'h00;
  localparam logic [3:0] IP_VERSION  = 4'd4;
  localparam logic [3:0] IHL_MIN     = 4'd5;
  localparam logic [7:0] PROTO_ICMP  = 8'd1;
  localparam logic [7:0] PROTO_TCP   = 8'd6;
  localparam logic [7:0] PROTO_UDP   = 8'd17;
  localparam logic [5:0] TCP_HDR_MIN = 6'd20;
  localparam logic [5:0] SHORT_HDR   = 6'd8;

  localparam logic [POS_W-1:0] POS_ETYPE_HI = 16'd12;
  localparam logic [POS_W-1:0] POS_ETYPE_LO = 16'd13;
  localparam logic [POS_W-1:0] POS_VER_IHL  = 16'd14;
  localparam logic [POS_W-1:0] POS_PROTO    = 16'd23;
  localparam logic [POS_W-1:0] POS_SRC_LO   = 16'd26;
  localparam logic [POS_W-1:0] POS_SRC_HI   = 16'd29;
  localparam logic [POS_W-1:0] POS_DST_LO   = 16'd30;
  localparam logic [POS_W-1:0] POS_DST_HI   = 16'd33;
  localparam logic [POS_W-1:0] ETH_HDR      = 16'd14;
  localparam logic [POS_W-1:0] PORT_BYTES   = 16'd4;
  localparam logic [POS_W-1:0] TCP_OFF_POS  = 16'd12;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_DISCARD
  } phase_t;

  typedef enum logic [1:0] {
    FM_ALL,
    FM_TCP,
    FM_UDP,
    FM_ICMP
  } filter_t;

  typedef enum logic [2:0] {
    ST_TCP,
    ST_UDP,
    ST_ICMP,
    ST_OTHER,
    ST_TRUNC
  } status_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } item_t;

  typedef struct packed {
    logic              result_kind;
    status_t           status;
    logic [31:0]       source_address;
    logic [31:0]       dest_address;
    logic [15:0]       source_port;
    logic [15:0]       dest_port;
    logic [7:0]        message_type;
    logic [7:0]        payload_value;
    logic [PIDX_W-1:0] payload_index;
    logic              last_of_frame;
  } result_t;

  function automatic status_t proto_status(input logic [7:0] proto);
    status_t st;
    case (proto)
      PROTO_TCP:  st = ST_TCP;
      PROTO_UDP:  st = ST_UDP;
      PROTO_ICMP: st = ST_ICMP;
      default:    st = ST_OTHER;
    endcase
    return st;
  endfunction

  function automatic logic filter_pass(input filter_t mode, input logic [7:0] proto);
    logic ok;
    unique case (mode)
      FM_TCP:  ok = (proto == PROTO_TCP);
      FM_UDP:  ok = (proto == PROTO_UDP);
      FM_ICMP: ok = (proto == PROTO_ICMP);
      default: ok = 1'b1;
    endcase
    return ok;
  endfunction

endpackage

[rtl/core/etp_in_reg.sv]
// Input register of the transport header parser.
// Holds one byte item until the parse stage takes it; uses etp_pkg.
module etp_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_tdata,
  input  logic           in_tlast,
  input  logic           take,
  output logic           item_valid,
  output etp_pkg::item_t item
);

  logic            valid_r;
  logic            valid_nxt;
  etp_pkg::item_t  item_r;

  assign in_tready  = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.frame_byte <= in_tdata;
      item_r.frame_end  <= in_tlast;
    end
  end

endmodule

[rtl/core/etp_parse.sv]
// Frame state and per-byte decode of the transport header parser.
// Updates the frame state on each byte taken and forms the result; uses etp_pkg.
module etp_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  etp_pkg::item_t   item,
  input  etp_pkg::filter_t filter_mode,
  output logic             res_valid,
  output etp_pkg::result_t res
);

  logic [etp_pkg::POS_W-1:0]  pos_r, pos_nxt;
  etp_pkg::phase_t            phase_r, phase_nxt;
  logic [5:0]                 ihb_r, ihb_nxt;
  logic [5:0]                 thb_r, thb_nxt;
  logic [7:0]                 proto_r, proto_nxt;
  logic [31:0]                src_r, src_nxt;
  logic [31:0]                dst_r, dst_nxt;
  logic [31:0]                ports_r, ports_nxt;
  logic [etp_pkg::PCNT_W-1:0] pcnt_r, pcnt_nxt;

  logic [7:0]                b;
  logic                      drop;
  logic [etp_pkg::POS_W-1:0] p_inc;
  logic [etp_pkg::POS_W-1:0] thdr_start;
  logic [etp_pkg::POS_W-1:0] thdr_end;
  logic [etp_pkg::POS_W-1:0] rel;
  logic                      is_tcp;
  logic                      is_udp;
  logic                      is_icmp;
  etp_pkg::status_t          st;
  logic                      last;

  assign b = item.frame_byte;

  always_comb begin
    pos_nxt    = pos_r;
    phase_nxt  = phase_r;
    ihb_nxt    = ihb_r;
    thb_nxt    = thb_r;
    proto_nxt  = proto_r;
    src_nxt    = src_r;
    dst_nxt    = dst_r;
    ports_nxt  = ports_r;
    pcnt_nxt   = pcnt_r;
    res_valid  = 1'b0;
    res        = '0;
    drop       = 1'b0;
    p_inc      = pos_r + 16'd1;
    thdr_start = '0;
    thdr_end   = '0;
    rel        = '0;
    is_tcp     = 1'b0;
    is_udp     = 1'b0;
    is_icmp    = 1'b0;
    st         = etp_pkg::ST_OTHER;
    last       = 1'b0;

    if (pos_r != etp_pkg::POS_MAX) begin
      if (phase_r == etp_pkg::PH_HEADER) begin
        if (pos_r == etp_pkg::POS_ETYPE_HI && b != etp_pkg::ETYPE_HI) begin
          drop = 1'b1;
        end
        if (pos_r == etp_pkg::POS_ETYPE_LO && b != etp_pkg::ETYPE_LO) begin
          drop = 1'b1;
        end
        if (pos_r == etp_pkg::POS_VER_IHL) begin
          if (b[7:4] != etp_pkg::IP_VERSION || b[3:0] < etp_pkg::IHL_MIN) begin
            drop = 1'b1;
          end else begin
            ihb_nxt = {b[3:0], 2'b00};
          end
        end
        if (pos_r == etp_pkg::POS_PROTO) begin
          if (!etp_pkg::filter_pass(filter_mode, b)) begin
            drop = 1'b1;
          end else begin
            proto_nxt = b;
            if (b == etp_pkg::PROTO_TCP) begin
              thb_nxt = etp_pkg::TCP_HDR_MIN;
            end else if (b == etp_pkg::PROTO_UDP || b == etp_pkg::PROTO_ICMP) begin
              thb_nxt = etp_pkg::SHORT_HDR;
            end else begin
              thb_nxt = '0;
            end
          end
        end

        if (drop) begin
          phase_nxt = etp_pkg::PH_DISCARD;
        end else begin
          if (pos_r >= etp_pkg::POS_SRC_LO && pos_r <= etp_pkg::POS_SRC_HI) begin
            src_nxt = {src_r[23:0], b};
          end
          if (pos_r >= etp_pkg::POS_DST_LO && pos_r <= etp_pkg::POS_DST_HI) begin
            dst_nxt = {dst_r[23:0], b};
          end
          if (pos_r >= etp_pkg::POS_PROTO) begin
            is_tcp     = (proto_nxt == etp_pkg::PROTO_TCP);
            is_udp     = (proto_nxt == etp_pkg::PROTO_UDP);
            is_icmp    = (proto_nxt == etp_pkg::PROTO_ICMP);
            st         = etp_pkg::proto_status(proto_nxt);
            thdr_start = etp_pkg::ETH_HDR + {10'd0, ihb_nxt};
            rel        = pos_r - thdr_start;
            if (pos_r >= thdr_start) begin
              if ((is_tcp || is_udp) && rel < etp_pkg::PORT_BYTES) begin
                ports_nxt = {ports_r[23:0], b};
              end
              if (is_tcp && rel == etp_pkg::TCP_OFF_POS) begin
                if (b[7:4] < etp_pkg::IHL_MIN) begin
                  thb_nxt = etp_pkg::TCP_HDR_MIN;
                end else begin
                  thb_nxt = {b[7:4], 2'b00};
                end
              end
              if (is_icmp && rel == '0) begin
                ports_nxt = {24'd0, b};
              end
            end
            thdr_end = thdr_start + {10'd0, thb_nxt};
            if (p_inc == thdr_end) begin
              res_valid          = 1'b1;
              res.result_kind    = 1'b0;
              res.status         = st;
              res.source_address = src_nxt;
              res.dest_address   = dst_nxt;
              if (is_tcp || is_udp) begin
                last             = item.frame_end || (p_inc == etp_pkg::POS_MAX);
                res.source_port  = ports_nxt[31:16];
                res.dest_port    = ports_nxt[15:0];
                res.last_of_frame = last;
                phase_nxt        = last ? etp_pkg::PH_DISCARD : etp_pkg::PH_PAYLOAD;
              end else begin
                res.message_type  = is_icmp ? ports_nxt[7:0] : 8'd0;
                res.last_of_frame = 1'b1;
                phase_nxt         = etp_pkg::PH_DISCARD;
              end
            end
          end
        end
      end else if (phase_r == etp_pkg::PH_PAYLOAD) begin
        pcnt_nxt           = pcnt_r + 1'b1;
        last               = item.frame_end || (pcnt_nxt >= etp_pkg::PCNT_LIMIT)
                             || (p_inc == etp_pkg::POS_MAX);
        res_valid          = 1'b1;
        res.result_kind    = 1'b1;
        res.status         = etp_pkg::proto_status(proto_r);
        res.source_address = src_r;
        res.dest_address   = dst_r;
        res.source_port    = ports_r[31:16];
        res.dest_port      = ports_r[15:0];
        res.payload_value  = b;
        res.payload_index  = pcnt_r[etp_pkg::PIDX_W-1:0];
        res.last_of_frame  = last;
        if (pcnt_nxt >= etp_pkg::PCNT_LIMIT) begin
          phase_nxt = etp_pkg::PH_DISCARD;
        end
      end
    end

    if (item.frame_end) begin
      if (!res_valid && phase_nxt == etp_pkg::PH_HEADER) begin
        res_valid         = 1'b1;
        res               = '0;
        res.status        = etp_pkg::ST_TRUNC;
        res.last_of_frame = 1'b1;
      end
      pos_nxt   = '0;
      phase_nxt = etp_pkg::PH_HEADER;
      ihb_nxt   = '0;
      thb_nxt   = '0;
      proto_nxt = '0;
      src_nxt   = '0;
      dst_nxt   = '0;
      ports_nxt = '0;
      pcnt_nxt  = '0;
    end else if (pos_r != etp_pkg::POS_MAX) begin
      pos_nxt = p_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= etp_pkg::PH_HEADER;
      ihb_r   <= '0;
      thb_r   <= '0;
      proto_r <= '0;
      src_r   <= '0;
      dst_r   <= '0;
      ports_r <= '0;
      pcnt_r  <= '0;
    end else if (step) begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      ihb_r   <= ihb_nxt;
      thb_r   <= thb_nxt;
      proto_r <= proto_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
      ports_r <= ports_nxt;
      pcnt_r  <= pcnt_nxt;
    end
  end

endmodule

[rtl/core/ethernet_ipv4_transport_header_parser.sv]
// Top level of the Ethernet/IPv4 transport header parser.
// Instantiates etp_in_reg and etp_parse and holds the result register; uses etp_pkg.
//
//   Channel   Direction  Payload
//   in_       slave      tdata: frame_byte; tlast: frame_end
//   out_      master     tdata: status..payload_index; tuser: result_kind; tlast: last_of_frame
//   cfg_      slave      cfg_data: filter_mode
//
// Each byte passes through the input register and then through the decode into the result
// register. One byte is accepted every cycle while the result side is ready; a waiting result
// stalls the decode and the input register behind it.
// Reset clears the frame state and sets the filter to all IPv4.
module ethernet_ipv4_transport_header_parser (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] frame_byte
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // [2:0] status, [34:3] source_address,
                                   // [66:35] dest_address, [82:67] source_port,
                                   // [98:83] dest_port, [106:99] message_type,
                                   // [114:107] payload_value, [118:115] payload_index,
                                   // [119] zero
  output logic         out_tuser,  // [0] result_kind
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_data
);

  etp_pkg::filter_t  filter_r;
  logic              item_valid;
  etp_pkg::item_t    item;
  logic              step;
  logic              res_valid;
  etp_pkg::result_t  res;
  logic              out_valid_r;
  logic              out_valid_nxt;
  etp_pkg::result_t  out_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_r <= etp_pkg::FM_ALL;
    end else if (cfg_valid && cfg_ready) begin
      filter_r <= etp_pkg::filter_t'(cfg_data);
    end
  end

  assign step = item_valid && (!out_valid_r || out_tready);

  etp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .take       (step),
    .item_valid (item_valid),
    .item       (item)
  );

  etp_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .item        (item),
    .filter_mode (filter_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = res_valid;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.result_kind;
  assign out_tlast  = out_r.last_of_frame;
  assign out_tdata  = {1'b0, out_r.payload_index, out_r.payload_value, out_r.message_type,
                       out_r.dest_port, out_r.source_port, out_r.dest_address,
                       out_r.source_address, out_r.status};

`ifndef NO_ASSERTIONS
  a_trunc_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == etp_pkg::ST_TRUNC |-> out_tlast && !out_tuser)
    else $error("truncated result is not a final summary");

  a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[2:0] == etp_pkg::ST_TCP || out_tdata[2:0] == etp_pkg::ST_UDP)
    else $error("payload item for a protocol without payload");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a waiting result");

  a_summary_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[114:107] == 8'd0 && out_tdata[118:115] == 4'd0)
    else $error("summary carries payload data");
`endif

endmodule

[tb/sv/ethernet_ipv4_transport_header_parser_tb.sv]
// Self-checking testbench for the Ethernet/IPv4 transport header parser.
// Sends directed and random frames byte by byte and checks every result against its own
// predictor of the parser or an expected truncation summary; it needs etp_pkg and the parser RTL.
module ethernet_ipv4_transport_header_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_DROP,
    CHK_TRUNC
  } row_check_t;

  typedef struct packed {
    etp_pkg::filter_t mode;
    logic [15:0]      etype;
    logic [7:0]       verihl;
    logic [7:0]       proto;
    logic [3:0]       doff;
    logic [15:0]      paylen;
    logic [7:0]       cut;
    row_check_t       chk;
  } frame_row_t;

  localparam int DIR_N = 24;
  localparam frame_row_t DIR_ROWS [DIR_N] = '{
    '{etp_pkg::FM_ALL,  16'h0800, 8'h45, etp_pkg::PROTO_TCP,  4'd5,  16'd0,  8'd0,  CHK_MODEL},
    '{etp_pkg::FM_ALL,  16'h0800, 8'h4F, etp_pkg::PROTO_TCP,  4'd15, 16'd20, 8'd0,  CHK_MODEL},
    '{etp_pkg::FM_ALL,  16'h0800, 8'h45, etp_pkg::PROTO_TCP,  4'd0,  16'd3,  8'd0,  CHK_MODEL},
    '{etp_pkg::FM_ALL,  16'h0800, 8'h45, etp_pkg::PROTO_TCP,  4'd5,  16'd12, 8'd60, CHK_MODEL},
    '{etp_pkg::FM_ALL,  16'h0800, 8'h45, etp_pkg::PROTO_UDP,  4'd0,  16'd16, 8'd0,  CHK_MODEL},
    '{etp_pkg::FM_ALL,  16'h0800, 8'h46, etp_pkg::PROTO_ICMP, 4'd0,  16'd4,  8'd0,  CHK_MODEL},
    '{etp_pkg::FM_ALL,  16'h0800, 8'h45, 8'hFF,               4'd0,  16'd3,  8'd0,  CHK_MODEL},
    '{etp_pkg::FM_ALL,  16'h0800, 8'h4F, 8'h00,               4'd0,  16'd0,  8'd0,  CHK_MODEL},
    '{etp_pkg::FM_ALL,  16'h0806, 8'h45, etp_pkg::PROTO_TCP,  4'd5,  16'd4,  8'd0,  CHK_DROP},
    '{etp_pkg::FM_ALL,  16'h0801, 8'h45, etp_pkg::PROTO_TCP,  4'd5,  16'd4,  8'd0,  CHK_DROP},
    '{etp_pkg::FM_ALL,  16'hFF00, 8'h45, etp_pkg::PROTO_UDP,  4'd0,  16'd4,  8'd0,  CHK_DROP},
    '{etp_pkg::FM_ALL,  16'h0800, 8'h65, etp_pkg::PROTO_TCP,  4'd5,  16'd4,  8'd0,  CHK_DROP},
    '{etp_pkg::FM_ALL,  16'h0800, 8'h44, etp_pkg::PROTO_UDP,  4'd0,  16'd4,  8'd0,  CHK_DROP},
    '{etp_pkg::FM_ALL,  16'h0800, 8'h40, etp_pkg::PROTO_TCP,  4'd5,  16'd4,  8'd0,  CHK_DROP},
    '{etp_pkg::FM_ALL,  16'h0800, 8'h45, etp_pkg::PROTO_TCP,  4'd5,  16'd0,  8'd1,  CHK_TRUNC},
    '{etp_pkg::FM_ALL,  16'h0800, 8'h45, etp_pkg::PROTO_TCP,  4'd5,  16'd0,  8'd30, CHK_TRUNC},
    '{etp_pkg::FM_ALL,  16'h0800, 8'h45, etp_pkg::PROTO_UDP,  4'd0,  16'd0,  8'd41, CHK_TRUNC},
    '{etp_pkg::FM_TCP,  16'h0800, 8'h45, etp_pkg::PROTO_UDP,  4'd0,  16'd4,  8'd0,  CHK_DROP},
    '{etp_pkg::FM_TCP,  16'h0800, 8'h45, etp_pkg::PROTO_TCP,  4'd6,  16'd2,  8'd0,  CHK_MODEL},
    '{etp_pkg::FM_UDP,  16'h0800, 8'h45, etp_pkg::PROTO_UDP,  4'd0,  16'd5,  8'd0,  CHK_MODEL},
    '{etp_pkg::FM_UDP,  16'h0800, 8'h45, etp_pkg::PROTO_ICMP, 4'd0,  16'd2,  8'd0,  CHK_DROP},
    '{etp_pkg::FM_ICMP, 16'h0800, 8'h45, etp_pkg::PROTO_ICMP, 4'd0,  16'd0,  8'd0,  CHK_MODEL},
    '{etp_pkg::FM_ICMP, 16'h0800, 8'h45, etp_pkg::PROTO_TCP,  4'd5,  16'd2,  8'd0,  CHK_DROP},
    '{etp_pkg::FM_ICMP, 16'h0800, 8'h45, etp_pkg::PROTO_TCP,  4'd5,  16'd0,  8'd20, CHK_TRUNC}
  };

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [119:0] out_tdata;
  logic         out_tuser;
  logic         out_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_data = '0;

  // Predictor state
  etp_pkg::filter_t filt;
  int unsigned      frm_pos;
  etp_pkg::phase_t  frm_phase;
  int unsigned      ip_hdr_len;
  int unsigned      l4_hdr_len;
  logic [7:0]       frm_proto;
  logic [31:0]      frm_src;
  logic [31:0]      frm_dst;
  logic [31:0]      frm_ports;
  int unsigned      pay_cnt;

  etp_pkg::result_t pending_results [$];
  logic [7:0]       pkt [$];
  int unsigned      bytes_sent = 0;
  int unsigned      burst_left = 0;
  int unsigned      results_seen = 0;
  int unsigned      mismatches = 0;
  int unsigned      hold_left = 0;
  int unsigned      hold_at = 40;

  ethernet_ipv4_transport_header_parser uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  initial begin
    #40ms;
    $display("FAIL ethernet_ipv4_transport_header_parser");
    $finish;
  end

  function automatic void clear_frame();
    frm_pos    = 0;
    frm_phase  = etp_pkg::PH_HEADER;
    ip_hdr_len = 0;
    l4_hdr_len = 0;
    frm_proto  = '0;
    frm_src    = '0;
    frm_dst    = '0;
    frm_ports  = '0;
    pay_cnt    = 0;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, input bit fin,
                                    output etp_pkg::result_t r);
    int unsigned      p, t, rel, d;
    bit               hit, lst, pass;
    etp_pkg::status_t st;
    hit = 1'b0;
    r   = '0;
    p   = frm_pos;
    case (filt)
      etp_pkg::FM_TCP:  pass = (b == etp_pkg::PROTO_TCP);
      etp_pkg::FM_UDP:  pass = (b == etp_pkg::PROTO_UDP);
      etp_pkg::FM_ICMP: pass = (b == etp_pkg::PROTO_ICMP);
      default:          pass = 1'b1;
    endcase
    if (p < etp_pkg::MAX_FRAME_BYTES && frm_phase == etp_pkg::PH_HEADER) begin
      if ((p == 12 && b != etp_pkg::ETYPE_HI) || (p == 13 && b != etp_pkg::ETYPE_LO) ||
          (p == 14 && (b[7:4] != etp_pkg::IP_VERSION || b[3:0] < etp_pkg::IHL_MIN)) ||
          (p == 23 && !pass)) begin
        frm_phase = etp_pkg::PH_DISCARD;
      end else begin
        if (p == 14) ip_hdr_len = b[3:0] * 4;
        if (p == 23) begin
          frm_proto  = b;
          l4_hdr_len = (b == etp_pkg::PROTO_TCP) ? 20 :
                       (b == etp_pkg::PROTO_UDP || b == etp_pkg::PROTO_ICMP) ? 8 : 0;
        end
        if (p >= 26 && p <= 29) frm_src = {frm_src[23:0], b};
        if (p >= 30 && p <= 33) frm_dst = {frm_dst[23:0], b};
        if (p >= 23) begin
          t = 14 + ip_hdr_len;
          case (frm_proto)
            etp_pkg::PROTO_TCP:  st = etp_pkg::ST_TCP;
            etp_pkg::PROTO_UDP:  st = etp_pkg::ST_UDP;
            etp_pkg::PROTO_ICMP: st = etp_pkg::ST_ICMP;
            default:             st = etp_pkg::ST_OTHER;
          endcase
          if (p >= t) begin
            rel = p - t;
            if ((st == etp_pkg::ST_TCP || st == etp_pkg::ST_UDP) && rel < 4)
              frm_ports = {frm_ports[23:0], b};
            if (st == etp_pkg::ST_TCP && rel == 12) begin
              d = b[7:4] * 4;
              l4_hdr_len = (d < 20) ? 20 : d;
            end
            if (st == etp_pkg::ST_ICMP && rel == 0) frm_ports = {24'd0, b};
          end
          if (p + 1 == t + l4_hdr_len) begin
            hit              = 1'b1;
            r.status         = st;
            r.source_address = frm_src;
            r.dest_address   = frm_dst;
            if (st == etp_pkg::ST_TCP || st == etp_pkg::ST_UDP) begin
              lst             = fin || (p + 1 >= etp_pkg::MAX_FRAME_BYTES);
              r.source_port   = frm_ports[31:16];
              r.dest_port     = frm_ports[15:0];
              r.last_of_frame = lst;
              frm_phase       = lst ? etp_pkg::PH_DISCARD : etp_pkg::PH_PAYLOAD;
            end else begin
              r.message_type  = (st == etp_pkg::ST_ICMP) ? frm_ports[7:0] : 8'd0;
              r.last_of_frame = 1'b1;
              frm_phase       = etp_pkg::PH_DISCARD;
            end
          end
        end
      end
    end else if (p < etp_pkg::MAX_FRAME_BYTES && frm_phase == etp_pkg::PH_PAYLOAD) begin
      hit              = 1'b1;
      r.result_kind    = 1'b1;
      r.status         = (frm_proto == etp_pkg::PROTO_TCP) ? etp_pkg::ST_TCP : etp_pkg::ST_UDP;
      r.source_address = frm_src;
      r.dest_address   = frm_dst;
      r.source_port    = frm_ports[31:16];
      r.dest_port      = frm_ports[15:0];
      r.payload_value  = b;
      r.payload_index  = pay_cnt[3:0];
      pay_cnt++;
      r.last_of_frame  = fin || pay_cnt >= etp_pkg::PAYLOAD_BYTES ||
                         (p + 1 >= etp_pkg::MAX_FRAME_BYTES);
      if (pay_cnt >= etp_pkg::PAYLOAD_BYTES) frm_phase = etp_pkg::PH_DISCARD;
    end
    if (fin) begin
      if (!hit && frm_phase == etp_pkg::PH_HEADER) begin
        hit             = 1'b1;
        r               = '0;
        r.status        = etp_pkg::ST_TRUNC;
        r.last_of_frame = 1'b1;
      end
      clear_frame();
    end else if (frm_pos < etp_pkg::MAX_FRAME_BYTES) begin
      frm_pos++;
    end
    return hit;
  endfunction

  task automatic build_frame(input logic [15:0] etype, input logic [7:0] verihl,
                             input logic [7:0] proto, input logic [3:0] doff,
                             input int paylen, input int cut);
    int unsigned ihl, l4;
    pkt.delete();
    repeat (12) pkt.push_back(8'($urandom));
    pkt.push_back(etype[15:8]);
    pkt.push_back(etype[7:0]);
    pkt.push_back(verihl);
    ihl = (verihl[3:0] < 5) ? 5 : verihl[3:0];
    repeat (8) pkt.push_back(8'($urandom));
    pkt.push_back(proto);
    repeat (ihl * 4 - 10) pkt.push_back(8'($urandom));
    if (proto == etp_pkg::PROTO_TCP) begin
      l4 = (doff < 5) ? 20 : doff * 4;
      for (int r = 0; r < l4; r++)
        pkt.push_back((r == 12) ? {doff, 4'($urandom)} : 8'($urandom));
    end else if (proto == etp_pkg::PROTO_UDP || proto == etp_pkg::PROTO_ICMP) begin
      repeat (8) pkt.push_back(8'($urandom));
    end
    repeat (paylen) pkt.push_back(8'($urandom));
    if (cut < 0) cut = $urandom_range(1, pkt.size());
    while (cut > 0 && pkt.size() > cut) void'(pkt.pop_back());
  endtask

  task automatic send_byte(input logic [7:0] b, input bit fin, input bit use_model);
    int unsigned      gap;
    etp_pkg::result_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
      burst_left = $urandom_range(1, 16);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    bytes_sent++;
    if (parse_byte(b, fin, r) && use_model) pending_results.push_back(r);
  endtask

  task automatic send_frame(input bit use_model);
    for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1, use_model);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_filter(input etp_pkg::filter_t mode);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    filt = mode;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 50)
      $display("%0t: %s mismatch, got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin
    etp_pkg::result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      got.result_kind    = out_tuser;
      got.status         = etp_pkg::status_t'(out_tdata[2:0]);
      got.source_address = out_tdata[34:3];
      got.dest_address   = out_tdata[66:35];
      got.source_port    = out_tdata[82:67];
      got.dest_port      = out_tdata[98:83];
      got.message_type   = out_tdata[106:99];
      got.payload_value  = out_tdata[114:107];
      got.payload_index  = out_tdata[118:115];
      got.last_of_frame  = out_tlast;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[31:0], 32'd0);
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", got.result_kind, want.result_kind);
        check_field("status", got.status, want.status);
        check_field("source_address", got.source_address, want.source_address);
        check_field("dest_address", got.dest_address, want.dest_address);
        check_field("source_port", got.source_port, want.source_port);
        check_field("dest_port", got.dest_port, want.dest_port);
        check_field("message_type", got.message_type, want.message_type);
        check_field("payload_value", got.payload_value, want.payload_value);
        check_field("payload_index", got.payload_index, want.payload_index);
        check_field("last_of_frame", got.last_of_frame, want.last_of_frame);
      end
    end
  end

  // The result side stalls in windows of varying density, and now and then holds off
  // for a long stretch so that the parser backs up into its input.
  initial begin
    int unsigned win_left, win_kind;
    win_left = 0;
    win_kind = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && results_seen >= hold_at) begin
        hold_left = 300;
        hold_at   = hold_at + 500;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        if (win_left == 0) begin
          win_left = $urandom_range(16, 80);
          win_kind = $urandom_range(0, 2);
        end
        win_left--;
        case (win_kind)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 3) != 0);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    etp_pkg::result_t trunc_res;
    int unsigned      target, nfr, pick;
    logic [7:0]       proto;
    logic [3:0]       ihl, doff;
    filt = etp_pkg::FM_ALL;
    clear_frame();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < DIR_N; k++) begin
      if (DIR_ROWS[k].mode != filt) set_filter(DIR_ROWS[k].mode);
      build_frame(DIR_ROWS[k].etype, DIR_ROWS[k].verihl, DIR_ROWS[k].proto,
                  DIR_ROWS[k].doff, DIR_ROWS[k].paylen, DIR_ROWS[k].cut);
      send_frame(DIR_ROWS[k].chk == CHK_MODEL);
      if (DIR_ROWS[k].chk == CHK_TRUNC) begin
        trunc_res               = '0;
        trunc_res.status        = etp_pkg::ST_TRUNC;
        trunc_res.last_of_frame = 1'b1;
        pending_results.push_back(trunc_res);
      end
    end
    set_filter(etp_pkg::FM_ALL);

    target = bytes_sent + 500;
    nfr    = 0;
    while (bytes_sent < target) begin
      if (nfr % 6 == 5) set_filter(etp_pkg::filter_t'($urandom_range(0, 3)));
      case ($urandom_range(0, 7))
        0, 1:    proto = etp_pkg::PROTO_TCP;
        2, 3:    proto = etp_pkg::PROTO_UDP;
        4:       proto = etp_pkg::PROTO_ICMP;
        5:       proto = 8'($urandom);
        default: begin
          case (filt)
            etp_pkg::FM_TCP:  proto = etp_pkg::PROTO_TCP;
            etp_pkg::FM_UDP:  proto = etp_pkg::PROTO_UDP;
            etp_pkg::FM_ICMP: proto = etp_pkg::PROTO_ICMP;
            default:          proto = 8'($urandom);
          endcase
        end
      endcase
      ihl  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
      doff = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd5;
      pick = $urandom_range(0, 99);
      if (pick < 70)
        build_frame({etp_pkg::ETYPE_HI, etp_pkg::ETYPE_LO}, {etp_pkg::IP_VERSION, ihl},
                    proto, doff, $urandom_range(0, 20), 0);
      else if (pick < 85)
        build_frame({etp_pkg::ETYPE_HI, etp_pkg::ETYPE_LO}, {etp_pkg::IP_VERSION, ihl},
                    proto, doff, $urandom_range(0, 20), -1);
      else if (pick < 92)
        build_frame({etp_pkg::ETYPE_HI, etp_pkg::ETYPE_LO}, 8'($urandom), proto, doff,
                    $urandom_range(0, 8), 0);
      else if (pick < 96)
        build_frame(16'($urandom), {etp_pkg::IP_VERSION, ihl}, proto, doff,
                    $urandom_range(0, 8), 0);
      else
        build_frame(16'($urandom), 8'($urandom), 8'($urandom), 4'($urandom), 0,
                    $urandom_range(1, 14));
      send_frame(1'b1);
      nfr++;
    end
    drain();

    if (mismatches == 0) begin
      $display("PASS ethernet_ipv4_transport_header_parser");
    end else begin
      $display("FAIL ethernet_ipv4_transport_header_parser");
    end
    $finish;
  end

endmodule
